/* sv/ifah_pkg.sv */
package ifah_pkg;

  localparam logic [63:0] MIX_C1 = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_C2 = 64'h94D049BB133111EB;
  localparam logic [63:0] OFS_LO = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] OFS_HI = 64'hD1B54A32D192ED03;
  localparam logic [63:0] OFS_PR = 64'h94D049BB133111EB;
  localparam logic [63:0] OFS_KEY = 64'hDB4F0B9175AE2165;
  localparam int unsigned MAX_WORKERS = 256;
  localparam int unsigned WID_W = $clog2(MAX_WORKERS);

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] PROTO_SCTP = 8'd132;

  // mixer command and status
  typedef struct packed {
    logic        start;
    logic [63:0] value;
  } mix_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] value;
  } mix_rsp_t;

endpackage

/* sv/ip_flow_affinity_hash.sv */
// Sequence: one byte a cycle while s_tready is high; the result of an accepted packet
// follows its last-byte transaction after a check step, four or five mixer passes
// (five with a fragment key) and the modulo. A rejected packet reports straight
// after the check step.
// Throughput: input stalls from the last byte until the cycle after the result
// transaction. Reset: synchronous; worker_count returns to 1, parse state clears.
module ip_flow_affinity_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // flow_hash, worker_id
  output logic        m_tuser    // accepted
);

  localparam logic [2:0] P_RX   = 3'd0;
  localparam logic [2:0] P_MSTA = 3'd1;
  localparam logic [2:0] P_MWT  = 3'd2;
  localparam logic [2:0] P_MOD  = 3'd3;
  localparam logic [2:0] P_OUT  = 3'd4;

  logic [2:0]  phase;
  logic [8:0]  worker_count;
  logic [15:0] byte_count;
  logic [3:0]  ip_version, header_words;
  logic [15:0] declared_length, frag_word, identification;
  logic [7:0]  protocol_number;
  logic [31:0] source_word, dest_word;
  logic [15:0] source_port, dest_port;
  logic [63:0] hash_accumulator;
  logic [63:0] lo, hi, pr, ky;
  logic [2:0]  step;
  logic        use_key, ok;
  logic        res_ok;
  logic [7:0]  res_wid;

  ifah_pkg::mix_req_t mreq;
  ifah_pkg::mix_rsp_t mrsp;
  logic        mod_start, mod_done;
  logic [ifah_pkg::WID_W-1:0] mod_rem;
  logic [8:0]  wc;

  ifah_mix u_mix (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));
  ifah_mod u_mod (.clk(clk), .rst(rst), .start(mod_start), .dividend(hash_accumulator),
                  .divisor(wc), .done(mod_done), .rem(mod_rem));

  assign wc = (worker_count == 9'd0) ? 9'd1 :
              (worker_count > 9'(ifah_pkg::MAX_WORKERS)) ?
              9'(ifah_pkg::MAX_WORKERS) : worker_count;

  logic [15:0] len;
  logic [16:0] hl;
  logic        proto_ok;
  logic [47:0] a, b;
  logic [15:0] sp, dp;
  logic [16:0] key;
  logic [7:0]  pos8;
  logic [4:0]  shb;
  logic [31:0] bsh;
  logic        v4, v6;

  assign len = (byte_count == 16'hFFFF) ? byte_count : byte_count + 16'd1;
  assign hl = {11'd0, header_words, 2'b00};
  assign v4 = ip_version == 4'd4;
  assign v6 = ip_version == 4'd6;
  assign shb = {~byte_count[1:0], 3'b000};
  assign bsh = {24'd0, s_tdata} << shb;
  assign pos8 = byte_count[7:0];

  // parse checks after the closing byte is captured: byte_count holds the length
  always_comb begin
    ok = 1'b0; sp = 16'd0; dp = 16'd0; key = 17'd0;
    proto_ok = 1'b0;
    if (v4) begin
      proto_ok = protocol_number == ifah_pkg::PROTO_TCP ||
                 protocol_number == ifah_pkg::PROTO_UDP ||
                 protocol_number == ifah_pkg::PROTO_SCTP;
      ok = byte_count >= 16'd20 && hl >= 17'd20 && {1'b0, byte_count} >= hl &&
           {1'b0, declared_length} >= hl && declared_length <= byte_count;
      if (frag_word[13:0] != 14'd0) key = {1'b1, identification};
      else if (proto_ok && {1'b0, declared_length} >= hl + 17'd4) begin
        sp = source_port; dp = dest_port;
      end
    end else if (v6) begin
      proto_ok = protocol_number == ifah_pkg::PROTO_TCP ||
                 protocol_number == ifah_pkg::PROTO_UDP;
      ok = byte_count >= 16'd40 && declared_length != 16'd0 &&
           {1'b0, declared_length} + 17'd40 <= {1'b0, byte_count};
      if (proto_ok && declared_length >= 16'd4 && byte_count >= 16'd44) begin
        sp = source_port; dp = dest_port;
      end
    end
    a = {source_word, sp};
    b = {dest_word, dp};
  end

  assign s_tready = phase == P_RX;
  assign m_tvalid = phase == P_OUT;
  assign m_tdata = {res_wid, hash_accumulator};
  assign m_tuser = res_ok;

  // mixer inputs: lo, hi, proto, key, then the final mix of the xor
  always_comb begin
    mreq.start = phase == P_MSTA && step != 3'd7;
    unique case (step)
      3'd0: mreq.value = lo;
      3'd1: mreq.value = hi;
      3'd2: mreq.value = pr;
      3'd3: mreq.value = ky;
      default: mreq.value = hash_accumulator;
    endcase
  end
  assign mod_start = phase == P_MOD && !mod_done && step == 3'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_RX;
      worker_count <= 9'd1;
      hash_accumulator <= 64'd0;
      byte_count <= 16'd0; ip_version <= 4'd0; header_words <= 4'd0;
      declared_length <= 16'd0; frag_word <= 16'd0; identification <= 16'd0;
      protocol_number <= 8'd0; source_word <= 32'd0; dest_word <= 32'd0;
      source_port <= 16'd0; dest_port <= 16'd0;
      step <= 3'd0; use_key <= 1'b0; res_ok <= 1'b0; res_wid <= 8'd0;
    end else begin
      if (cfg_we) worker_count <= cfg_wdata;
      unique case (phase)
        P_RX: if (s_tvalid) begin
          // capture header fields by position
          if (byte_count == 16'd0) begin
            ip_version <= s_tdata[7:4]; header_words <= s_tdata[3:0];
          end else if (v4) begin
            if (byte_count == 16'd2) declared_length[15:8] <= s_tdata;
            if (byte_count == 16'd3) declared_length[7:0] <= s_tdata;
            if (byte_count == 16'd4) identification[15:8] <= s_tdata;
            if (byte_count == 16'd5) identification[7:0] <= s_tdata;
            if (byte_count == 16'd6) frag_word[15:8] <= s_tdata;
            if (byte_count == 16'd7) frag_word[7:0] <= s_tdata;
            if (byte_count == 16'd9) protocol_number <= s_tdata;
            if (byte_count >= 16'd12 && byte_count < 16'd16)
              source_word <= source_word ^ bsh;
            if (byte_count >= 16'd16 && byte_count < 16'd20)
              dest_word <= dest_word ^ bsh;
            if (hl >= 17'd20) begin
              if ({1'b0, byte_count} == hl) source_port[15:8] <= s_tdata;
              if ({1'b0, byte_count} == hl + 17'd1) source_port[7:0] <= s_tdata;
              if ({1'b0, byte_count} == hl + 17'd2) dest_port[15:8] <= s_tdata;
              if ({1'b0, byte_count} == hl + 17'd3) dest_port[7:0] <= s_tdata;
            end
          end else if (v6 && byte_count[15:8] == 8'd0) begin
            if (pos8 == 8'd4) declared_length[15:8] <= s_tdata;
            if (pos8 == 8'd5) declared_length[7:0] <= s_tdata;
            if (pos8 == 8'd6) protocol_number <= s_tdata;
            if (pos8 >= 8'd8 && pos8 < 8'd24) source_word <= source_word ^ bsh;
            if (pos8 >= 8'd24 && pos8 < 8'd40) dest_word <= dest_word ^ bsh;
            if (pos8 == 8'd40) source_port[15:8] <= s_tdata;
            if (pos8 == 8'd41) source_port[7:0] <= s_tdata;
            if (pos8 == 8'd42) dest_port[15:8] <= s_tdata;
            if (pos8 == 8'd43) dest_port[7:0] <= s_tdata;
          end
          byte_count <= len;
          if (s_tlast) begin
            // close the packet; run the checks once the capture lands
            phase <= P_MSTA;
            step <= 3'd7;
          end
        end
        P_MSTA: begin
          if (step == 3'd7) begin
            // latch the verdict and the mixer operands
            res_ok <= ok;
            res_wid <= 8'd0;
            lo <= (a < b ? {16'd0, a} : {16'd0, b}) + ifah_pkg::OFS_LO;
            hi <= (a < b ? {16'd0, b} : {16'd0, a}) + ifah_pkg::OFS_HI;
            pr <= {56'd0, protocol_number} + ifah_pkg::OFS_PR;
            ky <= {47'd0, key} + ifah_pkg::OFS_KEY;
            use_key <= key != 17'd0;
            hash_accumulator <= 64'd0;
            if (ok) step <= 3'd0;
            else phase <= P_OUT;
          end else begin
            phase <= P_MWT;
          end
        end
        P_MWT: if (mrsp.done) begin
          if (step == 3'd4) begin
            hash_accumulator <= mrsp.value;
            step <= 3'd0;
            phase <= P_MOD;
          end else begin
            hash_accumulator <= hash_accumulator ^ mrsp.value;
            step <= (step == 3'd2 && !use_key) ? 3'd4 : step + 3'd1;
            phase <= P_MSTA;
          end
        end
        P_MOD: begin
          step <= 3'd1;
          if (mod_done) begin
            res_wid <= 8'(mod_rem);
            phase <= P_OUT;
          end
        end
        P_OUT: if (m_tready) begin
          phase <= P_RX;
          step <= 3'd0;
          if (!res_ok) hash_accumulator <= 64'd0;
          byte_count <= 16'd0; ip_version <= 4'd0; header_words <= 4'd0;
          declared_length <= 16'd0; frag_word <= 16'd0;
          identification <= 16'd0; protocol_number <= 8'd0;
          source_word <= 32'd0; dest_word <= 32'd0;
          source_port <= 16'd0; dest_port <= 16'd0;
        end
        default: phase <= P_RX;
      endcase
    end
  end

endmodule

/* sv/ifah_mix.sv */
// Iterative splitmix64 finalizer: one shift-xor or one 32x32 partial product
// per cycle through a single shared multiplier.
module ifah_mix (
  input  logic               clk,
  input  logic               rst,
  input  ifah_pkg::mix_req_t req,
  output ifah_pkg::mix_rsp_t rsp
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_X30  = 4'd1;
  localparam logic [3:0] S_M1A  = 4'd2;
  localparam logic [3:0] S_M1B  = 4'd3;
  localparam logic [3:0] S_M1C  = 4'd4;
  localparam logic [3:0] S_X27  = 4'd5;
  localparam logic [3:0] S_M2A  = 4'd6;
  localparam logic [3:0] S_M2B  = 4'd7;
  localparam logic [3:0] S_M2C  = 4'd8;
  localparam logic [3:0] S_X31  = 4'd9;

  logic [3:0]  state;
  logic [63:0] v;
  logic [63:0] acc;
  logic        done;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [63:0] c;

  assign c = (state == S_M1A || state == S_M1B || state == S_M1C) ?
             ifah_pkg::MIX_C1 : ifah_pkg::MIX_C2;

  // select operands of the shared multiplier
  always_comb begin
    unique case (state)
      S_M1A, S_M2A: begin ma = v[31:0];  mb = c[31:0];  end
      S_M1B, S_M2B: begin ma = v[31:0];  mb = c[63:32]; end
      S_M1C, S_M2C: begin ma = v[63:32]; mb = c[31:0];  end
      default:      begin ma = 32'd0;    mb = 32'd0;    end
    endcase
  end

  assign prod = {32'd0, ma} * {32'd0, mb};

  // sequence the finalizer steps
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (req.start) begin v <= req.value; state <= S_X30; end
        S_X30: begin v <= v ^ (v >> 30); state <= S_M1A; end
        S_M1A, S_M2A: begin acc <= prod; state <= state + 4'd1; end
        S_M1B, S_M2B: begin
          acc <= acc + {prod[31:0], 32'd0};
          state <= state + 4'd1;
        end
        S_M1C: begin v <= acc + {prod[31:0], 32'd0}; state <= S_X27; end
        S_X27: begin v <= v ^ (v >> 27); state <= S_M2A; end
        S_M2C: begin v <= acc + {prod[31:0], 32'd0}; state <= S_X31; end
        S_X31: begin v <= v ^ (v >> 31); done <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.value = v;

endmodule

/* sv/ifah_mod.sv */
// Restoring remainder of a 64-bit value by a 9-bit divisor, one bit a cycle.
module ifah_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [8:0]  divisor,
  output logic        done,
  output logic [ifah_pkg::WID_W-1:0] rem
);

  logic [63:0] sh;
  logic [9:0]  r;
  logic [6:0]  cnt;
  logic        busy;
  logic [9:0]  trial;

  assign trial = {r[8:0], sh[63]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      sh <= dividend;
      r <= 10'd0;
      cnt <= 7'd0;
    end else if (busy) begin
      sh <= sh << 1;
      r <= (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
      cnt <= cnt + 7'd1;
      if (cnt == 7'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rem = r[ifah_pkg::WID_W-1:0];

endmodule

/* sv/ifah_checker.sv */
module ifah_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic        m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(m_tvalid && s_tready))
    else $error("input ready while result pending");

  a_rej: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 72'd0)
    else $error("rejected packet carries hash");

  a_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("ready after last byte");

endmodule

bind ip_flow_affinity_hash ifah_checker u_chk (.*);

/* sim/ip_flow_affinity_hash_test.sv */
`timescale 1ns / 1ps

module ip_flow_affinity_hash_test;

  // One expected packet verdict
  typedef struct packed {
    logic        accepted;
    logic [63:0] flow_hash;
    logic [7:0]  worker_id;
  } verdict_t;

  // Flow hash predictor and store of pending verdicts
  class flow_scoreboard;
    int unsigned n_workers;
    int unsigned n_bytes;
    logic [3:0]  version;
    logic [3:0]  ihl;
    logic [15:0] length_field;
    logic [15:0] frag_bits;
    logic [15:0] ident;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] l4_src;
    logic [15:0] l4_dst;
    verdict_t    pending[$];
    int          errors;

    function new();
      n_workers = 1;
      errors = 0;
      clear();
    endfunction

    function void clear();
      n_bytes = 0; version = 0; ihl = 0; length_field = 0; frag_bits = 0;
      ident = 0; proto = 0; src_addr = 0; dst_addr = 0; l4_src = 0; l4_dst = 0;
    endfunction

    function logic [63:0] mix(logic [63:0] v);
      v = v ^ (v >> 30);
      v = v * ifah_pkg::MIX_C1;
      v = v ^ (v >> 27);
      v = v * ifah_pkg::MIX_C2;
      v = v ^ (v >> 31);
      return v;
    endfunction

    function void absorb(int unsigned pos, logic [7:0] b);
      int unsigned hl;
      int unsigned sh;
      hl = ihl * 4;
      sh = (3 - (pos % 4)) * 8;
      if (pos == 0) begin
        version = b[7:4];
        ihl = b[3:0];
      end else if (version == 4) begin
        case (pos)
          2: length_field[15:8] = b;
          3: length_field[7:0] = b;
          4: ident[15:8] = b;
          5: ident[7:0] = b;
          6: frag_bits[15:8] = b;
          7: frag_bits[7:0] = b;
          9: proto = b;
          default: begin
            if (pos >= 12 && pos < 16) src_addr ^= 32'(b) << sh;
            else if (pos >= 16 && pos < 20) dst_addr ^= 32'(b) << sh;
          end
        endcase
        if (hl >= 20) begin
          if (pos == hl) l4_src[15:8] = b;
          else if (pos == hl + 1) l4_src[7:0] = b;
          else if (pos == hl + 2) l4_dst[15:8] = b;
          else if (pos == hl + 3) l4_dst[7:0] = b;
        end
      end else if (version == 6) begin
        if (pos == 4) length_field[15:8] = b;
        else if (pos == 5) length_field[7:0] = b;
        else if (pos == 6) proto = b;
        else if (pos >= 8 && pos < 24) src_addr ^= 32'(b) << sh;
        else if (pos >= 24 && pos < 40) dst_addr ^= 32'(b) << sh;
        else if (pos == 40) l4_src[15:8] = b;
        else if (pos == 41) l4_src[7:0] = b;
        else if (pos == 42) l4_dst[15:8] = b;
        else if (pos == 43) l4_dst[7:0] = b;
      end
    endfunction

    // Work out the verdict for the packet just closed
    function verdict_t judge();
      verdict_t    v;
      int unsigned len, hl, tl, wc;
      logic [15:0] sp, dp;
      logic [16:0] key;
      logic        ok;
      logic [63:0] a, b, lo, hi, x;
      len = n_bytes; sp = 0; dp = 0; key = 0; ok = 1;
      if (version == 4) begin
        hl = ihl * 4;
        tl = length_field;
        if (len < 20 || hl < 20 || len < hl || tl < hl || tl > len) ok = 0;
        else if (frag_bits[13:0] != 0) key = {1'b1, ident};
        else if ((proto == ifah_pkg::PROTO_TCP || proto == ifah_pkg::PROTO_UDP ||
                  proto == ifah_pkg::PROTO_SCTP) && tl >= hl + 4) begin
          sp = l4_src; dp = l4_dst;
        end
      end else if (version == 6) begin
        tl = length_field;
        if (len < 40 || tl == 0 || tl + 40 > len) ok = 0;
        else if ((proto == ifah_pkg::PROTO_TCP || proto == ifah_pkg::PROTO_UDP) &&
                 tl >= 4 && len >= 44) begin
          sp = l4_src; dp = l4_dst;
        end
      end else begin
        ok = 0;
      end
      v = '0;
      if (ok) begin
        a = {16'd0, src_addr, sp};
        b = {16'd0, dst_addr, dp};
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        x = mix(lo + ifah_pkg::OFS_LO) ^ mix(hi + ifah_pkg::OFS_HI) ^
            mix(64'(proto) + ifah_pkg::OFS_PR);
        if (key != 0) x ^= mix(64'(key) + ifah_pkg::OFS_KEY);
        wc = (n_workers == 0) ? 1 :
             (n_workers > ifah_pkg::MAX_WORKERS ? ifah_pkg::MAX_WORKERS : n_workers);
        v.accepted = 1;
        v.flow_hash = mix(x);
        v.worker_id = 8'(v.flow_hash % wc);
      end
      return v;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      absorb(n_bytes, b);
      if (n_bytes < 65535) n_bytes++;
      if (last) begin
        pending.push_back(judge());
        clear();
      end
    endfunction

    function void check_verdict(logic acc, logic [71:0] data);
      verdict_t got, want;
      got.accepted = acc;
      got.flow_hash = data[63:0];
      got.worker_id = data[71:64];
      if (pending.size() == 0) begin
        $display("%0t: unexpected verdict %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.accepted !== want.accepted) begin
        $display("%0t: accepted exp %0d got %0d", $time, want.accepted, got.accepted);
        errors++;
      end
      if (got.flow_hash !== want.flow_hash) begin
        $display("%0t: flow_hash exp %h got %h", $time, want.flow_hash, got.flow_hash);
        errors++;
      end
      if (got.worker_id !== want.worker_id) begin
        $display("%0t: worker_id exp %0d got %0d", $time, want.worker_id, got.worker_id);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [8:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // data_byte
  logic        s_tlast;   // last_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;   // flow_hash, worker_id
  logic        m_tuser;   // accepted

  flow_scoreboard board;
  int unsigned    bytes_sent;
  bit             calm;
  logic [7:0]     pkt[$];

  ip_flow_affinity_hash DUT (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("ip_flow_affinity_hash_test NOT OK");
    $finish;
  end

  // Sink with random stalls; check each verdict
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) board.check_verdict(m_tuser, m_tdata);
      m_tready <= calm || ($urandom_range(99) >= 20);
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    while (!calm && $urandom_range(99) < 20) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_byte(b, last);
    bytes_sent++;
    // Drop valid after the closing byte; the block is busy right after it
    if (last) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic set_workers(logic [8:0] n);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 0;
    board.n_workers = n;
  endtask

  // Build a packet: bad picks a random corruption
  task automatic build(bit v6, logic [7:0] proto, bit frag, bit bad, int unsigned pay);
    int unsigned hl, tot, k;
    pkt.delete();
    if (v6) begin
      tot = 40 + pay;
      for (k = 0; k < tot; k++) pkt.push_back(8'($urandom));
      pkt[0] = 8'h60;
      {pkt[4], pkt[5]} = 16'(pay);
      pkt[6] = proto;
    end else begin
      hl = 4 * $urandom_range(5, 15);
      tot = hl + pay;
      for (k = 0; k < tot; k++) pkt.push_back(8'($urandom));
      pkt[0] = {4'h4, 4'(hl / 4)};
      {pkt[2], pkt[3]} = 16'(tot - $urandom_range(0, pay > 0 ? 1 : 0) * $urandom_range(0, pay));
      pkt[6] = frag ? pkt[6] : (pkt[6] & 8'hC0);
      pkt[7] = frag ? pkt[7] : 8'h00;
      if (frag && {pkt[6][5:0], pkt[7]} == 0) pkt[7] = 8'h01;
      pkt[9] = proto;
    end
    // Corrupt one field when asked
    if (bad) begin
      case ($urandom_range(3))
        0: pkt[0][7:4] = 4'($urandom);
        1: pkt[0][3:0] = 4'($urandom_range(0, 4));
        2: {pkt[2], pkt[3], pkt[4], pkt[5]} = $urandom;
        default: pkt = pkt[0:$urandom_range(0, pkt.size() - 1)];
      endcase
    end
  endtask

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(4))
      0: return ifah_pkg::PROTO_TCP;
      1: return ifah_pkg::PROTO_UDP;
      2: return ifah_pkg::PROTO_SCTP;
      3: return 8'($urandom);
      default: return ifah_pkg::PROTO_TCP;
    endcase
  endfunction

  initial begin
    int unsigned wsel;
    logic [8:0]  wlist[6];
    wlist = '{9'd0, 9'd1, 9'd256, 9'd511, 9'd7, 9'd100};
    board = new();
    calm = 0;
    bytes_sent = 0;
    rst <= 1;
    cfg_we <= 0;
    cfg_wdata <= 0;
    s_tvalid <= 0;
    s_tdata <= 0;
    s_tlast <= 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: single byte, short, each protocol, fragment, v6, extremes
    pkt = {8'hFF}; send_packet();
    pkt = {8'h00, 8'hFF}; send_packet();
    build(0, ifah_pkg::PROTO_TCP, 0, 0, 8); send_packet();
    build(0, ifah_pkg::PROTO_UDP, 0, 0, 4); send_packet();
    build(0, ifah_pkg::PROTO_SCTP, 0, 0, 0); send_packet();
    build(0, ifah_pkg::PROTO_TCP, 1, 0, 8); send_packet();
    build(1, ifah_pkg::PROTO_TCP, 0, 0, 8); send_packet();
    build(1, ifah_pkg::PROTO_UDP, 0, 0, 2); send_packet();
    build(1, ifah_pkg::PROTO_UDP, 0, 0, 0); send_packet();
    set_workers(9'd256);
    build(0, ifah_pkg::PROTO_TCP, 0, 0, 20); send_packet();
    build(1, 8'hFF, 0, 0, 10); send_packet();

    // Random packets, mostly well formed, across worker settings
    while (bytes_sent < 1200) begin
      if ($urandom_range(7) == 0) begin
        wsel = $urandom_range(0, 5);
        set_workers(wsel == 5 ? 9'($urandom_range(1, 511)) : wlist[wsel]);
      end
      calm = (bytes_sent > 500 && bytes_sent < 800);
      if ($urandom_range(9) == 0) begin
        pkt.delete();
        repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom));
      end else begin
        build(1'($urandom_range(1)), pick_proto(), $urandom_range(3) == 0,
              $urandom_range(5) == 0, $urandom_range(0, 24));
      end
      send_packet();
    end
    calm = 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0)
      $display("ip_flow_affinity_hash_test OK");
    else
      $display("ip_flow_affinity_hash_test NOT OK");
    $finish;
  end

endmodule

/* files.f */
sv/ifah_pkg.sv
sv/ifah_mix.sv
sv/ifah_mod.sv
sv/ip_flow_affinity_hash.sv
sv/ifah_checker.sv
sim/ip_flow_affinity_hash_test.sv
